/* rtl/crt_pkg.sv */
// ----------------------------------------------------------------------------
// crt_pkg
// shared types and constants of the chunk reassembly table
// ----------------------------------------------------------------------------
package crt_pkg;

	localparam int unsigned ENTRIES_DEF    = 16;
	localparam int unsigned MAX_CHUNKS_DEF = 16;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_COMPLETE  = 3'd2,
		ST_FULL      = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef enum logic {
		REG_TIMEOUT = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] message_id;
		logic [3:0]  chunk_index;
		logic [4:0]  chunk_count;
		logic [15:0] routing_tag;
		logic [15:0] chunk_handle;
		logic [31:0] now_ms;
	} chunk_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_message_id;
		logic [15:0] out_routing_tag;
		logic [3:0]  out_position;
		logic [15:0] out_handle;
		logic [4:0]  received_so_far;
		logic [4:0]  evicted_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic lookup;
		logic decide;
		logic emit_step;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic complete;
		logic emit_last;
	} stat_t;

endpackage

/* rtl/crt_ctrl.sv */
// ----------------------------------------------------------------------------
// crt_ctrl
// sequencer: table sweep, lookup, decision and in-order emission
// ----------------------------------------------------------------------------
module crt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  crt_pkg::stat_t stat,
	output crt_pkg::cmd_t  cmd,
	output logic          busy
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DRAIN, S_LOOKUP, S_DECIDE, S_EMIT, S_FLUSH
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.lookup    = (state_q == S_LOOKUP);
		cmd.decide    = (state_q == S_DECIDE);
		cmd.emit_step = (state_q == S_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						busy_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN:  state_q <= S_LOOKUP;
				S_LOOKUP: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (stat.complete) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_EMIT: begin
					if (stat.emit_last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

endmodule

/* rtl/crt_dp.sv */
// ----------------------------------------------------------------------------
// crt_dp
// entry table, chunk handle store, sweep logic and result register
// ----------------------------------------------------------------------------
module crt_dp #(
	parameter int unsigned ENTRIES    = crt_pkg::ENTRIES_DEF,
	parameter int unsigned MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  crt_pkg::cmd_t     cmd,
	input  crt_pkg::chunk_t   chunk,
	input  logic [15:0]      timeout,
	output crt_pkg::stat_t    stat,
	output crt_pkg::result_t  result,
	output logic             result_valid
);

	localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int unsigned SD = ENTRIES * (2 ** CW);

	typedef struct packed {
		logic [31:0]           id;
		logic [4:0]            total;
		logic [4:0]            received;
		logic [MAX_CHUNKS-1:0] bitmap;
		logic [31:0]           created;
		logic [15:0]           route;
	} meta_t;

	crt_pkg::chunk_t  in_q;
	logic [ENTRIES-1:0] valid_q;
	meta_t            meta_mem [ENTRIES];
	meta_t            meta_rd_s1;
	logic [15:0]      chunk_mem [SD];
	logic [15:0]      store_rd_q;

	logic [SW-1:0]    scan_idx_q;
	logic             scan_vld_s1;
	logic [SW-1:0]    scan_slot_s1;
	logic [4:0]       ev_q;
	logic             hit_found_q, free_found_q;
	logic [SW-1:0]    hit_slot_q, free_slot_q;

	logic [SW-1:0]    emit_slot_q;
	logic [4:0]       k_q, n_q;
	logic [15:0]      route_q;
	logic             emit_vld_s1, last_s1;
	logic [3:0]       pos_s1;

	crt_pkg::result_t result_q;
	logic             strobe_q;

	// sweep compare
	logic             stale, live_after;
	logic [31:0]      age;

	always_comb begin
		age        = in_q.now_ms - meta_rd_s1.created;
		stale      = valid_q[scan_slot_s1] && (age > {16'd0, timeout});
		live_after = valid_q[scan_slot_s1] && !stale;
	end

	// decision
	meta_t            cur;
	logic [SW-1:0]    cur_slot;
	logic             have_entry, single, do_write, done;
	logic [2:0]       dec_st;
	logic [MAX_CHUNKS-1:0] bit_m;
	logic [4:0]       new_rcv;
	crt_pkg::result_t one;

	always_comb begin
		cur        = meta_rd_s1;
		cur_slot   = hit_slot_q;
		have_entry = 1'b1;
		single     = 1'b1;
		do_write   = 1'b0;
		done       = 1'b0;
		dec_st     = crt_pkg::ST_STORED;
		bit_m      = MAX_CHUNKS'(1) << in_q.chunk_index;
		new_rcv    = 5'd0;
		if (!hit_found_q) begin
			have_entry   = 1'b0;
			cur.id       = in_q.message_id;
			cur.total    = in_q.chunk_count;
			cur.received = 5'd0;
			cur.bitmap   = '0;
			cur.created  = in_q.now_ms;
			cur.route    = in_q.routing_tag;
			cur_slot     = free_slot_q;
		end
		if (!hit_found_q && (in_q.chunk_count == 5'd0
				|| {2'b00, in_q.chunk_count} > 7'(MAX_CHUNKS)
				|| {1'b0, in_q.chunk_index} >= in_q.chunk_count)) begin
			dec_st = crt_pkg::ST_RANGE;
		end else if (!hit_found_q && !free_found_q) begin
			dec_st = crt_pkg::ST_FULL;
		end else if (hit_found_q && {1'b0, in_q.chunk_index} >= cur.total) begin
			dec_st  = crt_pkg::ST_RANGE;
			new_rcv = cur.received;
		end else if ((cur.bitmap & bit_m) != '0) begin
			dec_st  = crt_pkg::ST_DUPLICATE;
			new_rcv = cur.received;
		end else begin
			have_entry = 1'b1;
			do_write   = 1'b1;
			new_rcv    = cur.received + 5'd1;
			if (new_rcv == cur.total) begin
				done   = 1'b1;
				single = 1'b0;
			end
		end
		one.status          = dec_st;
		one.out_message_id  = in_q.message_id;
		one.out_routing_tag = (hit_found_q || have_entry) ? cur.route : in_q.routing_tag;
		one.out_position    = in_q.chunk_index;
		one.out_handle      = 16'd0;
		one.received_so_far = new_rcv;
		one.evicted_count   = ev_q;
		one.last            = 1'b1;
	end

	assign stat.scan_last = (scan_idx_q == SW'(ENTRIES - 1));
	assign stat.complete  = done;
	assign stat.emit_last = (k_q == n_q - 5'd1);

	// entry metadata memory
	meta_t         meta_wd;
	logic [SW-1:0] meta_ra;

	always_comb begin
		meta_wd          = cur;
		meta_wd.received = new_rcv;
		meta_wd.bitmap   = cur.bitmap | bit_m;
		meta_ra          = cmd.lookup ? hit_slot_q : scan_idx_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && do_write && !done) begin
			meta_mem[cur_slot] <= meta_wd;
		end
		meta_rd_s1 <= meta_mem[meta_ra];
	end

	// handle store
	always_ff @(posedge clk) begin
		if (cmd.decide && do_write) begin
			chunk_mem[{cur_slot, CW'(in_q.chunk_index)}] <= in_q.chunk_handle;
		end
		store_rd_q <= chunk_mem[{emit_slot_q, CW'(k_q)}];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= chunk;
		end
		if (cmd.decide) begin
			emit_slot_q <= cur_slot;
			n_q         <= cur.total;
			route_q     <= cur.route;
		end
		pos_s1  <= k_q[3:0];
		last_s1 <= stat.emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			scan_idx_q   <= '0;
			scan_vld_s1  <= 1'b0;
			scan_slot_s1 <= '0;
			ev_q         <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			hit_slot_q   <= '0;
			free_slot_q  <= '0;
			k_q          <= '0;
			emit_vld_s1  <= 1'b0;
			strobe_q     <= 1'b0;
			result_q     <= '0;
		end else begin
			scan_vld_s1  <= cmd.scan_step;
			scan_slot_s1 <= scan_idx_q;
			emit_vld_s1  <= cmd.emit_step;
			strobe_q     <= 1'b0;
			if (cmd.load) begin
				scan_idx_q   <= '0;
				ev_q         <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + SW'(1);
			end
			if (scan_vld_s1) begin
				if (stale) begin
					valid_q[scan_slot_s1] <= 1'b0;
					if (ev_q != 5'd31) begin
						ev_q <= ev_q + 5'd1;
					end
				end
				if (live_after && !hit_found_q && meta_rd_s1.id == in_q.message_id) begin
					hit_found_q <= 1'b1;
					hit_slot_q  <= scan_slot_s1;
				end
				if (!live_after && !free_found_q) begin
					free_found_q <= 1'b1;
					free_slot_q  <= scan_slot_s1;
				end
			end
			if (cmd.decide) begin
				k_q <= '0;
				if (do_write) begin
					valid_q[cur_slot] <= !done;
				end
				if (single) begin
					result_q <= one;
					strobe_q <= 1'b1;
				end
			end
			if (cmd.emit_step) begin
				k_q <= k_q + 5'd1;
			end
			if (emit_vld_s1) begin
				result_q.status          <= crt_pkg::ST_COMPLETE;
				result_q.out_message_id  <= in_q.message_id;
				result_q.out_routing_tag <= route_q;
				result_q.out_position    <= pos_s1;
				result_q.out_handle      <= store_rd_q;
				result_q.received_so_far <= n_q;
				result_q.evicted_count   <= ev_q;
				result_q.last            <= last_s1;
				strobe_q                 <= 1'b1;
			end
		end
	end

	assign result       = result_q;
	assign result_valid = strobe_q;

endmodule

/* rtl/chunk_reassembly_table.sv */
// ----------------------------------------------------------------------------
// chunk_reassembly_table
// message chunk reassembly with stale entry eviction
// ----------------------------------------------------------------------------
// A chunk is taken when start is high and busy is low. Each chunk walks the
// whole entry table once, one entry per cycle through the metadata memory
// read port; busy stays high through the sweep, drain, lookup and decide
// states. A chunk that completes its message then reads the handle store one
// chunk per cycle in the emit state and holds busy through emit and flush.
// Results come one per cycle on result with result_valid, the beats of a
// completion back to back, and cannot be held off; the final beat of an
// item has last set. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module chunk_reassembly_table #(
	parameter int unsigned ENTRIES    = crt_pkg::ENTRIES_DEF,
	parameter int unsigned MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  crt_pkg::chunk_t   chunk,
	output crt_pkg::result_t  result,
	output logic             result_valid,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	crt_pkg::cmd_t  cmd;
	crt_pkg::stat_t stat;
	logic [15:0]   timeout_q;
	logic          sel_timeout;

	assign pready      = 1'b1;
	assign sel_timeout = (paddr[2] == crt_pkg::REG_TIMEOUT);
	assign prdata      = sel_timeout ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= crt_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && sel_timeout) begin
			timeout_q <= pwdata[15:0];
		end
	end

	crt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	crt_dp #(
		.ENTRIES    (ENTRIES),
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.chunk        (chunk),
		.timeout      (timeout_q),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("beat right after final beat");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid &&
			result.status == crt_pkg::ST_COMPLETE)
		else $error("completion burst broken");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.status == crt_pkg::ST_COMPLETE)
		else $error("non-final beat outside completion");

endmodule

/* sim/chunk_reassembly_table_test.sv */
// ----------------------------------------------------------------------------
// chunk_reassembly_table_test
// checks chunk reassembly, duplicate and range rejects, table full drops and
// stale entry eviction against a behavioral table, across several timeouts
// ----------------------------------------------------------------------------
module chunk_reassembly_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NE = 16;
	localparam int NC = 16;
	localparam int WATCHDOG = 20000;

	class reassembly_board;
		logic [15:0] timeout;
		bit          valid [NE];
		logic [31:0] ids [NE];
		int          total [NE];
		int          rcvd [NE];
		logic [15:0] bitmap [NE];
		logic [31:0] created [NE];
		logic [15:0] route [NE];
		logic [15:0] handles [NE][NC];
		crt_pkg::result_t pending [$];
		int          errors;
		int          beats;
		int          completions;
		int          evictions;

		function new();
			timeout = crt_pkg::TIMEOUT_RESET;
			errors = 0;
			beats = 0;
			completions = 0;
			evictions = 0;
			foreach (valid[e]) begin
				valid[e] = 0;
				bitmap[e] = '0;
			end
		endfunction

		function void add(crt_pkg::status_t st, logic [31:0] id, logic [15:0] tag, int pos,
				logic [15:0] hnd, int rcv, int ev, bit lst);
			crt_pkg::result_t r;
			r.status = st;
			r.out_message_id = id;
			r.out_routing_tag = tag;
			r.out_position = pos[3:0];
			r.out_handle = hnd;
			r.received_so_far = rcv[4:0];
			r.evicted_count = ev[4:0];
			r.last = lst;
			pending.push_back(r);
		endfunction

		function void note_chunk(crt_pkg::chunk_t c);
			int ev;
			int hit;
			int fr;
			int n;
			logic [31:0] age;
			ev = 0;
			hit = -1;
			fr = -1;
			for (int e = 0; e < NE; e++) begin
				age = c.now_ms - created[e];
				if (valid[e] && age > {16'd0, timeout}) begin
					valid[e] = 0;
					bitmap[e] = '0;
					if (ev < 31) ev++;
				end
			end
			evictions += ev;
			for (int e = 0; e < NE; e++) begin
				if (valid[e]) begin
					if (hit < 0 && ids[e] == c.message_id) hit = e;
				end else if (fr < 0) begin
					fr = e;
				end
			end
			if (hit < 0) begin
				if (c.chunk_count == 0 || c.chunk_count > NC || c.chunk_index >= c.chunk_count) begin
					add(crt_pkg::ST_RANGE, c.message_id, c.routing_tag, int'(c.chunk_index),
						16'd0, 0, ev, 1'b1);
					return;
				end
				if (fr < 0) begin
					add(crt_pkg::ST_FULL, c.message_id, c.routing_tag, int'(c.chunk_index),
						16'd0, 0, ev, 1'b1);
					return;
				end
				hit = fr;
				valid[hit] = 1;
				ids[hit] = c.message_id;
				total[hit] = int'(c.chunk_count);
				rcvd[hit] = 0;
				bitmap[hit] = '0;
				created[hit] = c.now_ms;
				route[hit] = c.routing_tag;
			end else if (int'(c.chunk_index) >= total[hit]) begin
				add(crt_pkg::ST_RANGE, c.message_id, route[hit], int'(c.chunk_index), 16'd0,
					rcvd[hit], ev, 1'b1);
				return;
			end
			if (bitmap[hit][c.chunk_index]) begin
				add(crt_pkg::ST_DUPLICATE, c.message_id, route[hit], int'(c.chunk_index), 16'd0,
					rcvd[hit], ev, 1'b1);
				return;
			end
			handles[hit][c.chunk_index] = c.chunk_handle;
			bitmap[hit][c.chunk_index] = 1'b1;
			rcvd[hit]++;
			if (rcvd[hit] != total[hit]) begin
				add(crt_pkg::ST_STORED, c.message_id, route[hit], int'(c.chunk_index), 16'd0,
					rcvd[hit], ev, 1'b1);
				return;
			end
			n = total[hit];
			for (int k = 0; k < n; k++)
				add(crt_pkg::ST_COMPLETE, c.message_id, route[hit], k, handles[hit][k], n, ev,
					k == n - 1);
			completions++;
			valid[hit] = 0;
			bitmap[hit] = '0;
		endfunction

		function void check_beat(crt_pkg::result_t got);
			crt_pkg::result_t w;
			beats++;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.status !== w.status) begin
				$error("status exp %0d got %0d", w.status, got.status); errors++;
			end
			if (got.out_message_id !== w.out_message_id) begin
				$error("out_message_id exp %h got %h", w.out_message_id, got.out_message_id);
				errors++;
			end
			if (got.out_routing_tag !== w.out_routing_tag) begin
				$error("out_routing_tag exp %h got %h", w.out_routing_tag, got.out_routing_tag);
				errors++;
			end
			if (got.out_position !== w.out_position) begin
				$error("out_position exp %0d got %0d", w.out_position, got.out_position);
				errors++;
			end
			if (got.out_handle !== w.out_handle) begin
				$error("out_handle exp %h got %h", w.out_handle, got.out_handle); errors++;
			end
			if (got.received_so_far !== w.received_so_far) begin
				$error("received_so_far exp %0d got %0d", w.received_so_far,
					got.received_so_far);
				errors++;
			end
			if (got.evicted_count !== w.evicted_count) begin
				$error("evicted_count exp %0d got %0d", w.evicted_count, got.evicted_count);
				errors++;
			end
			if (got.last !== w.last) begin
				$error("last exp %0d got %0d", w.last, got.last); errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	crt_pkg::chunk_t  chunk = '0;
	crt_pkg::result_t result;
	logic        result_valid;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	reassembly_board board = new();
	int          idle_cycles = 0;
	int          sent = 0;
	logic [31:0] clock_ms = 32'd5000;
	logic [31:0] id_pool [8];

	chunk_reassembly_table u_dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (result_valid === 1'b1) board.check_beat(result);
		if ((start && !busy) || result_valid === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog expired");
			$display("chunk_reassembly_table_test NOT OK");
			$finish;
		end
	end

	task automatic write_timeout(logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(4 * crt_pkg::REG_TIMEOUT);
		pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.timeout = v;
	endtask

	task automatic send(crt_pkg::chunk_t c);
		int gap;
		logic [127:0] junk;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap + 1) @(negedge clk);
		chunk <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_chunk(c);
		sent++;
		@(negedge clk);
		start <= 1'b0;
		junk = {$urandom, $urandom, $urandom, $urandom};
		chunk <= junk[$bits(crt_pkg::chunk_t)-1:0];
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic crt_pkg::chunk_t make(logic [31:0] id, int idx, int cnt,
			logic [31:0] t);
		crt_pkg::chunk_t c;
		c.message_id = id;
		c.chunk_index = idx[3:0];
		c.chunk_count = cnt[4:0];
		c.routing_tag = 16'($urandom);
		c.chunk_handle = 16'($urandom);
		c.now_ms = t;
		return c;
	endfunction

	task automatic send_message(logic [31:0] id, int cnt, logic [31:0] t);
		int order [$];
		for (int i = 0; i < cnt; i++) order.push_back(i);
		order.shuffle();
		foreach (order[i]) begin
			send(make(id, order[i], cnt, t));
			if ($urandom_range(0, 7) == 0) send(make(id, order[i], cnt, t));
		end
	endtask

	initial begin
		crt_pkg::chunk_t c;
		int cnt;
		int n;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, duplicate, range and count errors
		c = make(32'hFFFF_FFFF, 0, 16, 32'd0);
		c.routing_tag = 16'hFFFF;
		c.chunk_handle = 16'hFFFF;
		send(c);
		send(make(32'hFFFF_FFFF, 0, 16, 32'd1));
		send(make(32'hFFFF_FFFF, 15, 3, 32'd1));
		c = make(32'h0, 15, 16, 32'd2);
		c.routing_tag = 16'h0;
		c.chunk_handle = 16'h0;
		send(c);
		send(make(32'h5, 0, 0, 32'd2));
		send(make(32'h6, 0, 17, 32'd2));
		send(make(32'h7, 0, 31, 32'd2));
		send(make(32'h8, 3, 3, 32'd2));
		send(make(32'h9, 0, 1, 32'd3));
		send(make(32'hA, 1, 2, 32'd3));
		send(make(32'hA, 0, 2, 32'd3));
		for (int i = 0; i < 14; i++) send(make(32'h100 + i, 0, 2, 32'd4));
		send(make(32'h200, 0, 2, 32'd4));
		// sweep clears everything
		send(make(32'h300, 0, 1, 32'd2000));
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_timeout(16'd0);
				1: write_timeout(16'hFFFF);
				2: write_timeout(16'd50);
				3: write_timeout(16'($urandom_range(1, 400)));
				default: write_timeout(crt_pkg::TIMEOUT_RESET);
			endcase
			foreach (id_pool[i]) id_pool[i] = $urandom;
			for (int m = 0; m < 14; m++) begin
				clock_ms = clock_ms + $urandom_range(0, 60);
				if ($urandom_range(0, 15) == 0) clock_ms = clock_ms + 32'hFFFF_FF00;
				cnt = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(1, 4);
				n = $urandom_range(0, 3);
				if (n == 0) begin
					c = make($urandom, $urandom, $urandom, clock_ms);
					c.routing_tag = 16'($urandom);
					send(c);
				end else if (n == 1) begin
					send(make(id_pool[$urandom_range(0, 7)], $urandom_range(0, 15),
						$urandom_range(1, 16), clock_ms));
				end else begin
					send_message(id_pool[$urandom_range(0, 7)] ^ m, cnt, clock_ms);
				end
			end
			drain();
		end

		$display("sent %0d chunks, checked %0d beats, %0d completions, %0d evictions",
			sent, board.beats, board.completions, board.evictions);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("chunk_reassembly_table_test OK");
		end else begin
			$display("chunk_reassembly_table_test NOT OK");
		end
		$finish;
	end
endmodule
